[hw/rtl/vtg_pkg.sv]
// Shared types and constants for the vector tile geometry decoder.
`default_nettype none

package vtg_pkg;

	// Result kinds
	localparam logic [2:0] KIND_MOVE  = 3'd0;
	localparam logic [2:0] KIND_LINE  = 3'd1;
	localparam logic [2:0] KIND_CLOSE = 3'd2;
	localparam logic [2:0] KIND_OK    = 3'd3;
	localparam logic [2:0] KIND_ERR   = 3'd4;

	// Command codes of the geometry stream
	localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
	localparam logic [2:0] CMD_LINE_TO    = 3'd2;
	localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

	localparam int unsigned VARINT_MAX_BYTES = 10;

	localparam int unsigned IN_W  = 8;
	localparam int unsigned OUT_W = 104;   // 99 payload bits padded to whole bytes

	typedef struct packed {
		logic               last;
		logic        [31:0] repeat_res;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
		logic        [2:0]  kind;
	} res_t;

	// Up to two results produced by one byte
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

`default_nettype wire

[hw/rtl/vtg_decode.sv]
// Varint assembly, command decode and cursor update, one byte per enabled cycle.
`default_nettype none

module vtg_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [7:0]    geometry_byte,
	input  wire logic          buffer_end,
	output vtg_pkg::push_t     push
);

	typedef enum logic [1:0] {PH_CMD, PH_DX, PH_DY} phase_t;

	logic [63:0] acc_q,  acc_n;
	logic [3:0]  cnt_q,  cnt_n;
	phase_t      ph_q,   ph_n;
	logic        move_q, move_n;
	logic [31:0] rem_q,  rem_n;
	logic [31:0] dx_q,   dx_n;
	logic [31:0] cx_q,   cx_n;
	logic [31:0] cy_q,   cy_n;
	logic        err_q,  err_n;

	logic [5:0]  sh;
	logic [63:0] part;
	logic [63:0] v;
	logic [31:0] uz;
	logic [31:0] cmd_cnt;
	logic        bad;
	logic        has_res;
	logic [2:0]  res_kind;
	logic [31:0] res_rep;

	assign sh      = 6'({2'b00, cnt_q} << 3) - 6'({2'b00, cnt_q});
	assign part    = {57'd0, geometry_byte[6:0]} << sh;
	assign v       = acc_q | part;
	assign uz      = (v[31:0] >> 1) ^ {32{v[0]}};
	assign cmd_cnt = v[34:3];

	always_comb begin
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		ph_n     = ph_q;
		move_n   = move_q;
		rem_n    = rem_q;
		dx_n     = dx_q;
		cx_n     = cx_q;
		cy_n     = cy_q;
		err_n    = err_q;
		bad      = 1'b0;
		has_res  = 1'b0;
		res_kind = vtg_pkg::KIND_ERR;
		res_rep  = 32'd0;

		if (!err_q) begin
			if (cnt_q >= 4'(vtg_pkg::VARINT_MAX_BYTES)) begin
				bad = 1'b1;
			end else if (geometry_byte[7]) begin
				acc_n = v;
				cnt_n = cnt_q + 4'd1;
			end else begin
				acc_n = 64'd0;
				cnt_n = 4'd0;
				unique case (ph_q)
					PH_CMD: begin
						if (cmd_cnt == 32'd0) begin
							bad = 1'b1;
						end else if (v[2:0] == vtg_pkg::CMD_MOVE_TO ||
							v[2:0] == vtg_pkg::CMD_LINE_TO) begin
							move_n = (v[2:0] == vtg_pkg::CMD_MOVE_TO);
							rem_n  = cmd_cnt;
							ph_n   = PH_DX;
						end else if (v[2:0] == vtg_pkg::CMD_CLOSE_PATH) begin
							has_res  = 1'b1;
							res_kind = vtg_pkg::KIND_CLOSE;
							res_rep  = cmd_cnt;
						end else begin
							bad = 1'b1;
						end
					end
					PH_DX: begin
						dx_n = uz;
						ph_n = PH_DY;
					end
					PH_DY: begin
						cx_n     = cx_q + dx_q;
						cy_n     = cy_q + uz;
						has_res  = 1'b1;
						res_kind = move_q ? vtg_pkg::KIND_MOVE : vtg_pkg::KIND_LINE;
						res_rep  = 32'd1;
						rem_n    = rem_q - 32'd1;
						ph_n     = (rem_q == 32'd1) ? PH_CMD : PH_DX;
					end
					default: begin
						bad = 1'b1;
					end
				endcase
			end
		end
	end

	// Result assembly; every result carries the cursor as updated by this byte
	always_comb begin
		push.r0.pos_x      = cx_n;
		push.r0.pos_y      = cy_n;
		push.r1.pos_x      = cx_n;
		push.r1.pos_y      = cy_n;
		push.r0.kind       = vtg_pkg::KIND_ERR;
		push.r0.repeat_res = 32'd0;
		push.r0.last       = 1'b1;
		push.r1.kind       = vtg_pkg::KIND_OK;
		push.r1.repeat_res = 32'd0;
		push.r1.last       = 1'b1;
		push.num           = 2'd0;

		if (err_q) begin
			push.num = buffer_end ? 2'd1 : 2'd0;
		end else if (bad) begin
			push.num = 2'd1;
		end else if (buffer_end) begin
			if (ph_n != PH_CMD || cnt_n != 4'd0) begin
				push.num = 2'd1;
			end else if (has_res) begin
				push.r0.kind       = res_kind;
				push.r0.repeat_res = res_rep;
				push.r0.last       = 1'b0;
				push.num           = 2'd2;
			end else begin
				push.r0.kind = vtg_pkg::KIND_OK;
				push.num     = 2'd1;
			end
		end else if (has_res) begin
			push.r0.kind       = res_kind;
			push.r0.repeat_res = res_rep;
			push.num           = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cnt_q  <= '0;
			ph_q   <= PH_CMD;
			move_q <= 1'b0;
			rem_q  <= '0;
			dx_q   <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			err_q  <= 1'b0;
		end else if (en) begin
			if (buffer_end) begin
				acc_q  <= '0;
				cnt_q  <= '0;
				ph_q   <= PH_CMD;
				move_q <= 1'b0;
				rem_q  <= '0;
				dx_q   <= '0;
				cx_q   <= '0;
				cy_q   <= '0;
				err_q  <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				cnt_q  <= cnt_n;
				ph_q   <= ph_n;
				move_q <= move_n;
				rem_q  <= rem_n;
				dx_q   <= dx_n;
				cx_q   <= cx_n;
				cy_q   <= cy_n;
				err_q  <= err_n | bad;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/vtg_outq.sv]
// Small result queue: takes up to two results a cycle, returns one while out_ready is high.
`default_nettype none

module vtg_outq #(
	parameter int unsigned QDEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vtg_pkg::push_t push,
	input  wire logic           push_en,
	output logic                room,
	output logic                out_valid,
	input  wire logic           out_ready,
	output vtg_pkg::res_t       out_res
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	vtg_pkg::res_t ent_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q, wp1, wp2, rp1;
	logic [CW-1:0] cnt_q;
	logic [1:0]    num;
	logic          pop;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		inc = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1       = inc(wp_q);
	assign wp2       = inc(wp1);
	assign rp1       = inc(rp_q);
	assign num       = push_en ? push.num : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign out_res   = ent_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= CW'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (num != 2'd0) begin
			ent_q[wp_q] <= push.r0;
		end
		if (num == 2'd2) begin
			ent_q[wp1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (num == 2'd1) begin
				wp_q <= wp1;
			end else if (num == 2'd2) begin
				wp_q <= wp2;
			end
			if (pop) begin
				rp_q <= rp1;
			end
			cnt_q <= cnt_q + CW'(num) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/vector_tile_geometry_decoder_top.sv]
// Top level of the vector tile geometry decoder.
//
// Usage:
//   Slave channel (s_*): one geometry byte per transaction in s_tdata, with
//   s_tlast high on the final byte of a geometry buffer.
//   Master channel (m_*): one result per transaction. m_tdata carries kind,
//   pos_x, pos_y and repeat_res; m_tlast marks the final result caused by a
//   given input byte. A byte causes zero, one or two results.
// Path: a byte taken sits in the input register and is decoded once the
//   queue has room for two results; its results are written into the
//   result queue, which offers the first of them on m_tdata.
// Throughput: one byte per unstalled cycle, bounded by the varint shift-or,
//   command decode and the 32-bit cursor add between the input register
//   and the result queue. Bytes that cause two results (a point or close_path
//   on the final byte, then the end status) drain at one result per cycle.
// Stalls: while m_tready is low the result queue absorbs results; the input
//   register keeps accepting until the queue lacks room for two more results,
//   then s_tready drops. Nothing is lost or repeated.
// Reset: arst_n clears the cursor, the varint assembler, the error flag and
//   the queue. The final byte of each buffer also returns the decoder to its
//   reset state.
`default_nettype none

module vector_tile_geometry_decoder_top #(
	parameter int unsigned QDEPTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [vtg_pkg::IN_W-1:0]      s_tdata,   // [7:0] geometry_byte
	input  wire logic                          s_tlast,   // buffer_end
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] kind, [34:3] pos_x, [66:35] pos_y, [98:67] repeat_res, rest zero
	output logic [vtg_pkg::OUT_W-1:0]          m_tdata,
	output logic                               m_tlast    // last
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           end_s1;
	logic           room;
	logic           take;
	vtg_pkg::push_t push;
	vtg_pkg::res_t  out_res;

	// Decode the held byte once the queue can take two results
	assign take     = valid_s1 && room;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	vtg_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (take),
		.geometry_byte (byte_s1),
		.buffer_end    (end_s1),
		.push          (push)
	);

	vtg_outq #(
		.QDEPTH (QDEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_en   (take),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'd0, out_res.repeat_res, out_res.pos_y, out_res.pos_x, out_res.kind};
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

[hw/rtl/vtg_checker.sv]
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

module vtg_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [vtg_pkg::OUT_W-1:0] m_tdata,
	input wire logic                     m_tlast
);

	logic [2:0]  kind;
	logic [31:0] rep;

	assign kind = m_tdata[2:0];
	assign rep  = m_tdata[98:67];

	// A stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_point_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == vtg_pkg::KIND_MOVE || kind == vtg_pkg::KIND_LINE)
		|-> rep == 32'd1)
		else $error("point result with repeat other than one");

	a_status_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == vtg_pkg::KIND_OK || kind == vtg_pkg::KIND_ERR)
		|-> rep == 32'd0 && m_tlast)
		else $error("status result malformed");

	a_close_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == vtg_pkg::KIND_CLOSE |-> rep != 32'd0)
		else $error("close_path with zero count");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[103:99] == 5'd0)
		else $error("padding bits set");

endmodule

bind vector_tile_geometry_decoder_top vtg_checker u_vtg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/vector_tile_geometry_decoder_top_tb.sv]
// Self-checking testbench for the vector tile geometry decoder top level.
`default_nettype none

module vector_tile_geometry_decoder_top_tb;
	import vtg_pkg::*;

	// Payload bits of one result in m_tdata (everything but last)
	localparam int PAYLOAD_BITS = $bits(res_t) - 1;
	// Run limit: far above the slowest legal run
	localparam int RUN_LIMIT = 10_000_000;
	// Random bytes to generate, not counting bytes dropped after an error
	localparam int RANDOM_BYTES = 1700;
	localparam int LONG_HOLD_CYCLES = 250;

	typedef enum logic [1:0] {PH_CMD, PH_DX, PH_DY} walk_phase_t;

	// One geometry byte to send; typed rows carry a hand-written expectation
	typedef struct {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		res_t       want;
	} geo_byte_t;

	// Directed row: typed rows are status results with the cursor at the origin
	// and a zero repeat count; kind is ignored on untyped rows.
	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       typed;
		logic [2:0] kind;
	} dir_row_t;

	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, KIND_ERR},  // zero count on the final byte of a buffer
		'{8'h0b, 1'b0, 1'b1, KIND_ERR},  // unknown command code 3
		'{8'h55, 1'b1, 1'b1, KIND_ERR},  // dropped after error, end status
		'{8'h09, 1'b0, 1'b0, KIND_OK},   // move_to, one point
		'{8'hfe, 1'b0, 1'b0, KIND_OK},   // dx = +2^31-1
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'h0f, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},   // dy: ten-byte varint, all ones -> -2^31
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'h7f, 1'b0, 1'b0, KIND_OK},   // tenth byte, payload above bit 63 dropped
		'{8'hff, 1'b0, 1'b0, KIND_OK},   // close_path, count 2^32-1
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'hff, 1'b0, 1'b0, KIND_OK},
		'{8'h7f, 1'b1, 1'b0, KIND_OK},   // close_path then end ok on one byte
		'{8'h12, 1'b1, 1'b1, KIND_ERR}   // buffer ends inside line_to operands
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_W-1:0]       m_tdata;
	logic                   m_tlast;

	// Decoder state mirrored by the predictor
	logic [63:0]  vint_acc;
	logic [3:0]   vint_len;
	walk_phase_t  walk;
	logic [2:0]   path_cmd;
	logic [31:0]  pts_left;
	logic [31:0]  dx_hold;
	logic [31:0]  cur_x;
	logic [31:0]  cur_y;
	logic         err_latched;

	geo_byte_t stim_q [$];        // every byte to send, in order
	res_t      step_results [$];  // results of the byte just decoded
	res_t      pending_results [$];  // results accepted bytes still owe

	int payload_cnt;
	int pause_at = -1;
	int in_cnt;
	int res_cnt;
	int buffers;
	int fails;
	int kind_seen [8];

	vector_tile_geometry_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	//------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------
	function automatic void clear_decoder();
		vint_acc = '0;
		vint_len = '0;
		walk = PH_CMD;
		path_cmd = '0;
		pts_left = '0;
		dx_hold = '0;
		cur_x = '0;
		cur_y = '0;
		err_latched = 1'b0;
	endfunction

	function automatic logic [31:0] from_zigzag(logic [31:0] v);
		return (v >> 1) ^ {32{v[0]}};
	endfunction

	function automatic res_t make_result(logic [2:0] k, logic [31:0] rep);
		return '{last: 1'b0, repeat_res: rep, pos_y: cur_y, pos_x: cur_x, kind: k};
	endfunction

	// Decodes one byte, leaving its results in step_results
	function automatic void decode_geometry_byte(logic [7:0] b, logic fin);
		logic [63:0] v;
		logic [31:0] cnt;
		bit          bad;

		step_results.delete();
		bad = 1'b0;
		if (!err_latched) begin
			if (vint_len >= VARINT_MAX_BYTES) begin
				bad = 1'b1;
			end else begin
				vint_acc |= 64'(b[6:0]) << (7 * vint_len);
				vint_len++;
				if (!b[7]) begin
					v = vint_acc;
					vint_acc = '0;
					vint_len = '0;
					case (walk)
						PH_CMD: begin
							cnt = v[34:3];
							if (cnt == '0) begin
								bad = 1'b1;
							end else if (v[2:0] == CMD_MOVE_TO || v[2:0] == CMD_LINE_TO) begin
								path_cmd = v[2:0];
								pts_left = cnt;
								walk = PH_DX;
							end else if (v[2:0] == CMD_CLOSE_PATH) begin
								step_results.push_back(make_result(KIND_CLOSE, cnt));
							end else begin
								bad = 1'b1;
							end
						end
						PH_DX: begin
							dx_hold = from_zigzag(v[31:0]);
							walk = PH_DY;
						end
						default: begin
							cur_x += dx_hold;
							cur_y += from_zigzag(v[31:0]);
							step_results.push_back(make_result(
								(path_cmd == CMD_MOVE_TO) ? KIND_MOVE : KIND_LINE, 32'd1));
							pts_left--;
							walk = (pts_left == '0) ? PH_CMD : PH_DX;
						end
					endcase
				end
			end
			if (bad) begin
				step_results.push_back(make_result(KIND_ERR, '0));
				err_latched = 1'b1;
			end else if (fin) begin
				// an end inside an item leaves the error status as the only result
				if (walk != PH_CMD || vint_len != '0) begin
					step_results.delete();
					step_results.push_back(make_result(KIND_ERR, '0));
				end else begin
					step_results.push_back(make_result(KIND_OK, '0));
				end
			end
		end else if (fin) begin
			step_results.push_back(make_result(KIND_ERR, '0));
		end
		if (step_results.size() > 0)
			step_results[step_results.size()-1].last = 1'b1;
		if (fin)
			clear_decoder();
	endfunction

	//------------------------------------------------------------------
	// Stimulus generation
	//------------------------------------------------------------------
	task automatic emit(logic [7:0] b, bit counted);
		stim_q.push_back('{b: b, fin: 1'b0, typed: 1'b0, want: '0});
		if (counted)
			payload_cnt++;
	endtask

	task automatic end_buffer();
		stim_q[stim_q.size()-1].fin = 1'b1;
	endtask

	// Little-endian base-128; now and then padded up to the ten-byte maximum
	task automatic put_varint(logic [63:0] v);
		int m, n, i;
		logic [7:0] b;

		m = 1;
		while (m < VARINT_MAX_BYTES && (v >> (7 * m)) != '0)
			m++;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(m, VARINT_MAX_BYTES) : m;
		for (i = 0; i < n; i++) begin
			b[6:0] = 7'(v >> (7 * i));
			if (i == VARINT_MAX_BYTES - 1)
				b[6:1] = 6'($urandom);  // bits beyond 63 are junk
			b[7] = (i < n - 1);
			emit(b, 1'b1);
		end
	endtask

	// Zigzag-coded delta, sometimes with junk above bit 31
	function automatic logic [63:0] delta_word();
		logic [31:0] d;
		logic [31:0] hi;

		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: d = 32'($urandom_range(0, 64)) - 32'd32;
			5, 6, 7:       d = $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0:       d = 32'h7fff_ffff;
					1:       d = 32'h8000_0000;
					2:       d = 32'hffff_ffff;
					default: d = '0;
				endcase
			end
		endcase
		hi = ($urandom_range(0, 7) == 0) ? $urandom : '0;
		return {hi, (d << 1) ^ {32{d[31]}}};
	endfunction

	function automatic logic [28:0] word_junk();
		return ($urandom_range(0, 7) == 0) ? 29'($urandom) : '0;
	endfunction

	// Well-formed run of commands with random content
	task automatic gen_path(int ncmds);
		int c, k;
		logic [2:0]  op;
		logic [31:0] cnt;

		for (c = 0; c < ncmds; c++) begin
			k = $urandom_range(0, 99);
			op = (k < 30) ? CMD_MOVE_TO : ((k < 75) ? CMD_LINE_TO : CMD_CLOSE_PATH);
			cnt = $urandom_range(1, 4);
			if (op == CMD_CLOSE_PATH && $urandom_range(0, 4) == 0) begin
				cnt = $urandom;
				if (cnt == '0)
					cnt = 32'd1;
			end
			put_varint({word_junk(), cnt, op});
			if (op != CMD_CLOSE_PATH) begin
				for (k = 0; k < int'(cnt); k++) begin
					put_varint(delta_word());
					put_varint(delta_word());
				end
			end
		end
	endtask

	task automatic build_stimulus();
		int i, k, start, cut;
		logic [2:0] op;

		for (i = 0; i < DIR_ROWS; i++) begin
			stim_q.push_back('{b: DIRECTED[i].b, fin: DIRECTED[i].fin,
				typed: DIRECTED[i].typed,
				want: '{last: 1'b1, repeat_res: '0, pos_y: '0, pos_x: '0,
					kind: DIRECTED[i].kind}});
		end

		payload_cnt = 0;
		while (payload_cnt < RANDOM_BYTES) begin
			// one sender pause, on a buffer boundary, once the run is well under way
			if (pause_at < 0 && payload_cnt >= RANDOM_BYTES / 2)
				pause_at = stim_q.size();
			k = $urandom_range(0, 99);
			if (k < 70) begin
				gen_path($urandom_range(1, 5));
			end else if (k < 80) begin
				// truncated buffer: ends at a random byte
				start = stim_q.size();
				gen_path($urandom_range(1, 3));
				cut = $urandom_range(start, stim_q.size() - 1);
				while (stim_q.size() > cut + 1) begin
					void'(stim_q.pop_back());
					payload_cnt--;
				end
			end else if (k < 87) begin
				// zero count or unknown command after a valid prefix
				gen_path($urandom_range(0, 2));
				if ($urandom_range(0, 1)) begin
					put_varint({word_junk(), 32'd0, 3'($urandom)});
				end else begin
					do
						op = 3'($urandom);
					while (op == CMD_MOVE_TO || op == CMD_LINE_TO || op == CMD_CLOSE_PATH);
					put_varint({word_junk(), 32'($urandom_range(1, 1000)), op});
				end
				repeat ($urandom_range(0, 5)) emit(8'($urandom), 1'b0);
			end else if (k < 93) begin
				// overlong varint: ten continuation bytes and an eleventh
				gen_path($urandom_range(0, 2));
				repeat (VARINT_MAX_BYTES) emit({1'b1, 7'($urandom)}, 1'b1);
				emit(8'($urandom), 1'b1);
				repeat ($urandom_range(0, 5)) emit(8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 12)) emit(8'($urandom), 1'b1);
			end
			end_buffer();
		end
	endtask

	//------------------------------------------------------------------
	// Clock, reset, limit
	//------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		clear_decoder();
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#RUN_LIMIT;
		$display("timeout: %0d of %0d bytes accepted, %0d results pending",
			in_cnt, stim_q.size(), pending_results.size());
		$display("[vector_tile_geometry_decoder_top] ERROR");
		$finish;
	end

	//------------------------------------------------------------------
	// Sender: bursts of random length, random gaps, one full pause
	//------------------------------------------------------------------
	initial begin : feed
		int idx, burst, gap;

		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		build_stimulus();
		wait (arst_n);
		@(posedge clk);

		idx = 0;
		while (idx < stim_q.size()) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && idx < stim_q.size()) begin
				if (idx == pause_at) begin
					// hold off until every result owed so far has been taken
					s_tvalid <= 1'b0;
					do
						@(posedge clk);
					while (pending_results.size() != 0);
				end
				s_tvalid <= 1'b1;
				s_tdata <= stim_q[idx].b;
				s_tlast <= stim_q[idx].fin;
				do
					@(posedge clk);
				while (!s_tready);
				idx++;
				burst--;
			end
			// about a third of the bursts run straight into the next one
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		// the last transaction's expectations were queued on the edge that accepted it
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch anything extra the block might still emit
		repeat (16) @(posedge clk);

		$display("sent %0d bytes in %0d buffers, checked %0d results", in_cnt, buffers, res_cnt);
		$display("kinds seen: move %0d, line %0d, close %0d, end ok %0d, error %0d",
			kind_seen[KIND_MOVE], kind_seen[KIND_LINE], kind_seen[KIND_CLOSE],
			kind_seen[KIND_OK], kind_seen[KIND_ERR]);
		if (fails == 0)
			$display("[vector_tile_geometry_decoder_top] OK");
		else
			$display("[vector_tile_geometry_decoder_top] ERROR");
		$finish;
	end

	//------------------------------------------------------------------
	// Receiver: stretches of ready, random and patterned stalls, one long hold
	//------------------------------------------------------------------
	initial begin : drain
		int mode, len, i;
		logic [7:0] stall_bits;
		bit long_hold_done;

		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && res_cnt >= 300) begin
				// long hold: the sender keeps offering so the block backs up
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len = (mode == 3) ? $urandom_range(1, 15) : $urandom_range(8, 60);
				stall_bits = 8'($urandom);
				for (i = 0; i < len; i++) begin
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= stall_bits[i % 8];
						default: m_tready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Input side: predict the results of each accepted transaction
	//------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			decode_geometry_byte(s_tdata, s_tlast);
			if (stim_q[in_cnt].typed) begin
				pending_results.push_back(stim_q[in_cnt].want);
			end else begin
				foreach (step_results[i])
					pending_results.push_back(step_results[i]);
			end
			if (s_tlast)
				buffers++;
			in_cnt++;
		end
	end

	//------------------------------------------------------------------
	// Output side: compare each accepted result with the oldest expectation
	//------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : watch_out
		res_t got;
		res_t want;

		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata[PAYLOAD_BITS-1:0]};
			if (pending_results.size() == 0) begin
				$error("result kind %0d at (%0h, %0h) with nothing expected",
					got.kind, got.pos_x, got.pos_y);
				fails++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("pos_x", want.pos_x, got.pos_x);
				check_field("pos_y", want.pos_y, got.pos_y);
				check_field("repeat_res", want.repeat_res, got.repeat_res);
				check_field("last", 32'(want.last), 32'(got.last));
				check_field("tdata pad", '0, 32'(m_tdata[OUT_W-1:PAYLOAD_BITS]));
			end
			kind_seen[got.kind]++;
			res_cnt++;
		end
	end

endmodule

`default_nettype wire
